// ----- design/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg: shared types and constants of the display source arbiter
// Event codes, decoded operations, priorities, update kinds and the command
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package dsa_pkg;

  // Field widths of the channels
  localparam int MODE_W     = 4;
  localparam int PRIO_W     = 2;
  localparam int FIELD_W    = 16;
  localparam int REV_W      = 32;
  localparam int KIND_W     = 2;

  // Width of a stored frame or scene handle
  localparam int HANDLE_W   = 16;

  // Command queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Event codes on the input channel
  localparam logic [MODE_W-1:0] MODE_SHOW_LOCAL  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SHOW_INTER  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_CLR_INTER   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_CLR_OVR     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_COMMIT      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CONNECT     = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DISCONNECT  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_RECONFIG    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_FAILED      = 4'd8;

  // Requested priority codes
  localparam logic [PRIO_W-1:0] PRIO_REQ_STARTUP  = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_REQ_CRITICAL = 2'd2;

  // Update kinds on the result channel
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCAL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOTE = 2'd2;

  // Decoded operation
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOCAL,
    OP_INTER,
    OP_CLR_INTER,
    OP_CLR_OVR,
    OP_COMMIT,
    OP_CONNECT,
    OP_DISCONNECT,
    OP_RECONFIG
  } op_t;

  // Normalized local priority
  typedef enum logic [1:0] {
    PRIO_NORMAL,
    PRIO_STARTUP,
    PRIO_CRITICAL
  } prio_t;

  typedef logic [HANDLE_W-1:0] handle_t;

  // Command held in the queue
  typedef struct packed {
    op_t              op;
    prio_t            prio;
    handle_t          frame;
    handle_t          scene;
    logic             full;
    logic [REV_W-1:0] rev;
  } cmd_t;

endpackage

// ----- design/dsa_if.sv -----
// ----------------------------------------------------------------------------
// dsa_if: channel interfaces of the display source arbiter
// Event channel into the block and update channel out of it, each with
// valid/ready flow control.
// ----------------------------------------------------------------------------
interface dsa_in_if import dsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PRIO_W-1:0]   priority_req;
  logic [FIELD_W-1:0]  frame_handle;
  logic [FIELD_W-1:0]  scene_handle;
  logic                scene_full;
  logic [REV_W-1:0]    scene_revision;

  modport source (
    output valid, mode, priority_req, frame_handle, scene_handle, scene_full,
           scene_revision,
    input  ready
  );
  modport sink (
    input  valid, mode, priority_req, frame_handle, scene_handle, scene_full,
           scene_revision,
    output ready
  );
endinterface

interface dsa_out_if import dsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   update_kind;
  logic [FIELD_W-1:0]  shown_frame;
  logic [FIELD_W-1:0]  shown_scene;
  logic                full_redraw;
  logic [REV_W-1:0]    current_revision;

  modport source (
    output valid, update_kind, shown_frame, shown_scene, full_redraw,
           current_revision,
    input  ready
  );
  modport sink (
    input  valid, update_kind, shown_frame, shown_scene, full_redraw,
           current_revision,
    output ready
  );
endinterface

// ----- design/dsa_front.sv -----
// ----------------------------------------------------------------------------
// dsa_front: event decoder
// Accepts event items, maps the mode and priority codes to an operation and
// a normalized priority, and pushes the command into the queue.
// ----------------------------------------------------------------------------
module dsa_front import dsa_pkg::*; (
  dsa_in_if.sink in_ch,
  input  logic   q_full,
  output logic   push,
  output cmd_t   push_cmd
);

  op_t   op;
  prio_t prio;

  // Accept while the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Classify the event; a failure acts as a critical local frame
  always_comb begin
    op   = OP_NONE;
    prio = PRIO_NORMAL;
    unique case (in_ch.mode)
      MODE_SHOW_LOCAL: begin
        op = OP_LOCAL;
        if (in_ch.priority_req == PRIO_REQ_CRITICAL) begin
          prio = PRIO_CRITICAL;
        end else if (in_ch.priority_req == PRIO_REQ_STARTUP) begin
          prio = PRIO_STARTUP;
        end
      end
      MODE_SHOW_INTER: op = OP_INTER;
      MODE_CLR_INTER:  op = OP_CLR_INTER;
      MODE_CLR_OVR:    op = OP_CLR_OVR;
      MODE_COMMIT:     op = OP_COMMIT;
      MODE_CONNECT:    op = OP_CONNECT;
      MODE_DISCONNECT: op = OP_DISCONNECT;
      MODE_RECONFIG:   op = OP_RECONFIG;
      MODE_FAILED: begin
        op   = OP_LOCAL;
        prio = PRIO_CRITICAL;
      end
      default:         op = OP_NONE;
    endcase
  end

  // Build the command
  always_comb begin
    push_cmd.op    = op;
    push_cmd.prio  = prio;
    push_cmd.frame = HANDLE_W'(in_ch.frame_handle);
    push_cmd.scene = HANDLE_W'(in_ch.scene_handle);
    push_cmd.full  = in_ch.scene_full;
    push_cmd.rev   = in_ch.scene_revision;
  end

endmodule

// ----- design/dsa_queue.sv -----
// ----------------------------------------------------------------------------
// dsa_queue: command queue
// Short FIFO between the decoder and the state engine so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module dsa_queue import dsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = mem[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/dsa_back.sv -----
// ----------------------------------------------------------------------------
// dsa_back: state engine and update register
// Applies one command a cycle, while the update register is free or being
// drained, to the link, override and source flags and to the stored frames
// and scene, and registers the resulting display update.
module dsa_back import dsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  dsa_out_if.source   out_ch
);

  typedef enum logic [1:0] {
    WANT_NONE,
    WANT_LOCAL,
    WANT_REMOTE
  } want_t;

  // Control flags
  logic link_up_r,     link_up_nxt;
  logic link_lost_r,   link_lost_nxt;
  logic ovr_on_r,      ovr_on_nxt;
  logic ovr_saved_r,   ovr_saved_nxt;
  logic src_remote_r,  src_remote_nxt;
  logic inter_valid_r, inter_valid_nxt;
  logic local_valid_r, local_valid_nxt;
  logic remote_valid_r, remote_valid_nxt;

  // Stored content, undefined until written
  handle_t          inter_frame_r, inter_frame_nxt;
  handle_t          local_frame_r, local_frame_nxt;
  handle_t          remote_scene_r, remote_scene_nxt;
  logic [REV_W-1:0] remote_rev_r, remote_rev_nxt;

  // Output register
  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [FIELD_W-1:0] frame_r, frame_nxt;
  logic [FIELD_W-1:0] scene_r, scene_nxt;
  logic               full_r, full_nxt;
  logic [REV_W-1:0]   rev_r, rev_nxt;

  want_t want;
  logic  want_full;

  // Take a command whenever the update register is free or being drained
  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  // Next state and requested update
  always_comb begin
    link_up_nxt      = link_up_r;
    link_lost_nxt    = link_lost_r;
    ovr_on_nxt       = ovr_on_r;
    ovr_saved_nxt    = ovr_saved_r;
    src_remote_nxt   = src_remote_r;
    inter_valid_nxt  = inter_valid_r;
    local_valid_nxt  = local_valid_r;
    remote_valid_nxt = remote_valid_r;
    inter_frame_nxt  = inter_frame_r;
    local_frame_nxt  = local_frame_r;
    remote_scene_nxt = remote_scene_r;
    remote_rev_nxt   = remote_rev_r;
    want             = WANT_NONE;
    want_full        = 1'b1;

    unique case (q_cmd.op)
      OP_LOCAL: begin
        if (link_lost_r) begin
          want = WANT_LOCAL;
        end else begin
          local_frame_nxt = q_cmd.frame;
          local_valid_nxt = 1'b1;
          if (q_cmd.prio == PRIO_CRITICAL) begin
            inter_valid_nxt = 1'b0;
          end
          priority if (inter_valid_nxt) begin
            want = WANT_NONE;
          end else if (q_cmd.prio == PRIO_STARTUP) begin
            if (ovr_on_r) begin
              src_remote_nxt = 1'b0;
              want           = WANT_LOCAL;
            end else if (remote_valid_r) begin
              src_remote_nxt = 1'b1;
              want           = WANT_REMOTE;
            end else begin
              src_remote_nxt = 1'b0;
              want           = WANT_LOCAL;
            end
          end else if (q_cmd.prio == PRIO_CRITICAL) begin
            ovr_on_nxt     = 1'b1;
            src_remote_nxt = 1'b0;
            want           = WANT_LOCAL;
          end else if (!(ovr_on_r || src_remote_r)) begin
            want = WANT_LOCAL;
          end
        end
      end
      OP_INTER: begin
        inter_frame_nxt = q_cmd.frame;
        inter_valid_nxt = 1'b1;
        src_remote_nxt  = 1'b0;
        want            = WANT_LOCAL;
      end
      OP_CLR_INTER: begin
        if (inter_valid_r) begin
          inter_valid_nxt = 1'b0;
          if (link_lost_r || ovr_on_r || !remote_valid_r) begin
            src_remote_nxt = 1'b0;
            want           = WANT_LOCAL;
          end else begin
            src_remote_nxt = 1'b1;
            want           = WANT_REMOTE;
          end
        end
      end
      OP_CLR_OVR: begin
        if (ovr_on_r) begin
          ovr_on_nxt = 1'b0;
          if (remote_valid_r) begin
            src_remote_nxt = 1'b1;
            want           = WANT_REMOTE;
          end else begin
            src_remote_nxt = 1'b0;
            want           = WANT_LOCAL;
          end
        end
      end
      OP_COMMIT: begin
        // Drop commits while the link is down or partial scenes with no base
        if (link_up_r && (remote_valid_r || q_cmd.full)) begin
          remote_scene_nxt = q_cmd.scene;
          remote_rev_nxt   = q_cmd.rev;
          remote_valid_nxt = 1'b1;
          if (!(ovr_on_r || inter_valid_r)) begin
            src_remote_nxt = 1'b1;
            want           = WANT_REMOTE;
            want_full      = q_cmd.full;
          end
        end
      end
      OP_CONNECT: begin
        if (link_lost_r) begin
          ovr_on_nxt = ovr_saved_r;
        end
        link_up_nxt      = 1'b1;
        link_lost_nxt    = 1'b0;
        remote_valid_nxt = 1'b0;
        local_frame_nxt  = q_cmd.frame;
        local_valid_nxt  = 1'b1;
        src_remote_nxt   = 1'b0;
        want             = WANT_LOCAL;
      end
      OP_DISCONNECT: begin
        if (!link_lost_r) begin
          ovr_saved_nxt = ovr_on_r;
        end
        remote_valid_nxt = 1'b0;
        local_frame_nxt  = q_cmd.frame;
        local_valid_nxt  = 1'b1;
        ovr_on_nxt       = 1'b1;
        link_up_nxt      = 1'b0;
        link_lost_nxt    = 1'b1;
        src_remote_nxt   = 1'b0;
        want             = WANT_LOCAL;
      end
      OP_RECONFIG: begin
        if (inter_valid_r || !src_remote_r) begin
          want = WANT_LOCAL;
        end else begin
          want = WANT_REMOTE;
        end
      end
      default: want = WANT_NONE;
    endcase
  end

  // Resolve the update from the new state
  always_comb begin
    kind_nxt  = KIND_NONE;
    frame_nxt = '0;
    scene_nxt = '0;
    full_nxt  = 1'b0;
    unique case (want)
      WANT_LOCAL: begin
        if (inter_valid_nxt) begin
          kind_nxt  = KIND_LOCAL;
          frame_nxt = FIELD_W'(inter_frame_nxt);
          full_nxt  = 1'b1;
        end else if (local_valid_nxt) begin
          kind_nxt  = KIND_LOCAL;
          frame_nxt = FIELD_W'(local_frame_nxt);
          full_nxt  = 1'b1;
        end
      end
      WANT_REMOTE: begin
        if (remote_valid_nxt) begin
          kind_nxt  = KIND_REMOTE;
          scene_nxt = FIELD_W'(remote_scene_nxt);
          full_nxt  = want_full;
        end
      end
      default: kind_nxt = KIND_NONE;
    endcase
    rev_nxt = remote_valid_nxt ? remote_rev_nxt : '0;
  end

  // Hold control flags and the update valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_r      <= 1'b0;
      link_lost_r    <= 1'b0;
      ovr_on_r       <= 1'b0;
      ovr_saved_r    <= 1'b0;
      src_remote_r   <= 1'b0;
      inter_valid_r  <= 1'b0;
      local_valid_r  <= 1'b0;
      remote_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        link_up_r      <= link_up_nxt;
        link_lost_r    <= link_lost_nxt;
        ovr_on_r       <= ovr_on_nxt;
        ovr_saved_r    <= ovr_saved_nxt;
        src_remote_r   <= src_remote_nxt;
        inter_valid_r  <= inter_valid_nxt;
        local_valid_r  <= local_valid_nxt;
        remote_valid_r <= remote_valid_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold stored content and update payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      inter_frame_r  <= inter_frame_nxt;
      local_frame_r  <= local_frame_nxt;
      remote_scene_r <= remote_scene_nxt;
      remote_rev_r   <= remote_rev_nxt;
      kind_r         <= kind_nxt;
      frame_r        <= frame_nxt;
      scene_r        <= scene_nxt;
      full_r         <= full_nxt;
      rev_r          <= rev_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.update_kind      = kind_r;
  assign out_ch.shown_frame      = frame_r;
  assign out_ch.shown_scene      = scene_r;
  assign out_ch.full_redraw      = full_r;
  assign out_ch.current_revision = rev_r;

endmodule

// ----- design/display_source_arbiter.sv -----
// ----------------------------------------------------------------------------
// display_source_arbiter: top level of the display source arbiter
// Decodes display events, queues them, and turns each into one display update.
// ----------------------------------------------------------------------------
// The block takes one event item per clock while the command queue has room
// and returns exactly one update item per event, in order. An accepted event
// is decoded and written into a two-entry command queue; the state engine takes
// one command a cycle while the update register is free or being drained,
// updates the link, override and source flags, and registers the update; an
// event passes through a queue entry and the update register on its way out.
// Sustained rate is one item per cycle when the output does not stall, set by
// the state update; when the output stalls, the queue absorbs up to two further
// events before in_ch.ready drops. Stored frames and scene are read only once
// written; there is no clearing pass after reset.
module display_source_arbiter import dsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dsa_in_if.sink    in_ch,
  dsa_out_if.source out_ch
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  dsa_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  dsa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- design/dsa_checker.sv -----
// ----------------------------------------------------------------------------
// dsa_checker: port checks of the display source arbiter
// Watches the update channel for stall behavior and consistent update fields.
// ----------------------------------------------------------------------------
module dsa_checker import dsa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [KIND_W-1:0]  update_kind,
  input logic [FIELD_W-1:0] shown_frame,
  input logic [FIELD_W-1:0] shown_scene,
  input logic               full_redraw
);

  // A stalled update stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("update dropped while stalled");

  // Kind is a defined code and unused handle fields are zero
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((update_kind == KIND_NONE && shown_frame == '0 && shown_scene == '0)
                || (update_kind == KIND_LOCAL && shown_scene == '0)
                || (update_kind == KIND_REMOTE && shown_frame == '0)))
    else $error("update kind and handle fields disagree");

  // A local frame always redraws the whole display
  a_local_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && update_kind == KIND_LOCAL |-> full_redraw)
    else $error("local update without full redraw");

  // No update never asks for a redraw
  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && update_kind == KIND_NONE |-> !full_redraw)
    else $error("redraw requested with no update");

endmodule

bind display_source_arbiter dsa_checker u_dsa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .update_kind (out_ch.update_kind),
  .shown_frame (out_ch.shown_frame),
  .shown_scene (out_ch.shown_scene),
  .full_redraw (out_ch.full_redraw)
);
